FILE: design/mlfq_pkg.sv
package mlfq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W     = 4;
    localparam int SLICE_W  = 3;
    localparam int QUANTA_W = 16;
    localparam int BUDGET_W = 7;
    localparam int SCHED_W  = 8;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_STATE  = 2'd1,
        MODE_VALUED = 2'd2,
        MODE_YIELD  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        TS_READY      = 2'd0,
        TS_WAITING    = 2'd1,
        TS_TERMINATED = 2'd2,
        TS_RUNNING    = 2'd3
    } thr_status_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_IN_USE   = 2'd1,
        RES_NOT_USED = 2'd2,
        RES_SPARE    = 2'd3
    } res_code_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] thread;
        logic [3:0] slice;
        res_code_t  status;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CREDIT_WR,
        ST_LIFT,
        ST_SORT_START,
        ST_SORT_FIRST,
        ST_SORT_TAKE,
        ST_SORT_CMP,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_WALK_LINK,
        ST_SORT_END,
        ST_RET_RD,
        ST_RET_INFO,
        ST_RET_PUSH,
        ST_FILL_TRY,
        ST_FILL_POP,
        ST_DISP_RD,
        ST_DISP_INFO,
        ST_DISP_RUN,
        ST_OUT
    } state_t;

endpackage

FILE: design/mlfq_ram.sv
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/mlfq_thread_scheduler.sv
// Create, set state and set valued each return one result; a yield that finds round
//   entries left dispatches the next one, otherwise it first runs the maintenance pass
//   (lift, sort per level, return of round entries, refill), all on one next-pointer port.
// Throughput: one transaction at a time; s_tready is high only while the sequencer idles.
// Reset: rst_n clears slot flags, level counts, round and current thread, budget to 15.
module mlfq_thread_scheduler #(
    parameter int LEVELS      = 5,
    parameter int MAX_ROUND   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side: tuser = mode[1:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // thread_id[3:0], new_state[5:4], valued[6], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // next_thread[3:0], slice_quanta[7:4], status[9:8], pad
    output logic [0:0]  m_tuser,   // next_valid[0]
    // round budget register
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    localparam int MAX_THREADS = mlfq_pkg::MAX_THREADS;
    localparam int TW  = $clog2(MAX_THREADS);
    localparam int CW  = $clog2(MAX_THREADS + 1);
    localparam int LW  = $clog2(LEVELS);
    localparam int LCW = $clog2(LEVELS + 1);
    localparam int RIW = (MAX_ROUND > 1) ? $clog2(MAX_ROUND) : 1;
    localparam int RLW = $clog2(MAX_ROUND + 1);
    localparam int L3  = LEVELS / 3;
    localparam int QW  = mlfq_pkg::QUANTA_W;
    localparam int SW  = mlfq_pkg::SLICE_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mlfq_pkg::state_t  state_reg, state_next;
    mlfq_pkg::mode_t   mode_reg, mode_next;
    logic [3:0]        id_reg, id_next;
    logic [1:0]        ns_reg, ns_next;
    logic              val_reg, val_next;
    logic [6:0]        budget_reg;

    logic              slot_used_reg [MAX_THREADS];
    logic              slot_used_next [MAX_THREADS];

    // Each level is a linked list threaded through the next-pointer RAM; the list ends
    // by count, so the tail's pointer is never looked at.
    logic [TW-1:0]     head_reg [LEVELS];
    logic [TW-1:0]     head_next [LEVELS];
    logic [TW-1:0]     tail_reg [LEVELS];
    logic [TW-1:0]     tail_next [LEVELS];
    logic [CW-1:0]     cnt_reg [LEVELS];
    logic [CW-1:0]     cnt_next [LEVELS];

    logic [RLW-1:0]    round_len_reg, round_len_next;
    logic [RLW-1:0]    cursor_reg, cursor_next;
    logic [RLW-1:0]    k_reg, k_next;
    logic [TW-1:0]     cur_slot_reg, cur_slot_next;
    logic              cur_valid_reg, cur_valid_next;

    // Sequencer working registers
    logic [LCW-1:0]    lvl_reg, lvl_next;
    logic [LCW-1:0]    att_reg, att_next;
    logic [mlfq_pkg::SCHED_W-1:0] sched_reg, sched_next;
    logic [TW-1:0]     x_reg, x_next;
    logic [TW-1:0]     p_reg, p_next;
    logic [TW-1:0]     c_reg, c_next;
    logic [TW-1:0]     orig_reg, orig_next;
    logic [TW-1:0]     sh_reg, sh_next;
    logic [TW-1:0]     st_reg, st_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [QW-1:0]     rc_reg, rc_next;
    logic [QW-1:0]     front_rc_reg, front_rc_next;

    mlfq_pkg::res_t    pend_reg, pend_next;
    mlfq_pkg::res_t    out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    logic              nx_we;
    logic [TW-1:0]     nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic              ts_we;
    logic [TW-1:0]     ts_waddr, ts_raddr;
    logic [1:0]        ts_wdata, ts_rdata;
    logic              sl_we;
    logic [TW-1:0]     sl_waddr, sl_raddr;
    logic [SW-1:0]     sl_wdata, sl_rdata;
    logic              va_we;
    logic [TW-1:0]     va_waddr, va_raddr;
    logic [0:0]        va_wdata, va_rdata;
    logic              qu_we;
    logic [TW-1:0]     qu_waddr, qu_raddr;
    logic [QW-1:0]     qu_wdata, qu_rdata;
    logic              rl_we;
    logic [RIW-1:0]    rl_waddr, rl_raddr;
    logic [TW-1:0]     rl_wdata, rl_rdata;

    mlfq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );
    mlfq_ram #(.WIDTH(2), .DEPTH(MAX_THREADS)) u_status_ram (
        .clk(clk), .we(ts_we), .waddr(ts_waddr), .wdata(ts_wdata),
        .raddr(ts_raddr), .rdata(ts_rdata)
    );
    mlfq_ram #(.WIDTH(SW), .DEPTH(MAX_THREADS)) u_slice_ram (
        .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
        .raddr(sl_raddr), .rdata(sl_rdata)
    );
    mlfq_ram #(.WIDTH(1), .DEPTH(MAX_THREADS)) u_valued_ram (
        .clk(clk), .we(va_we), .waddr(va_waddr), .wdata(va_wdata),
        .raddr(va_raddr), .rdata(va_rdata)
    );
    mlfq_ram #(.WIDTH(QW), .DEPTH(MAX_THREADS)) u_quanta_ram (
        .clk(clk), .we(qu_we), .waddr(qu_waddr), .wdata(qu_wdata),
        .raddr(qu_raddr), .rdata(qu_rdata)
    );
    mlfq_ram #(.WIDTH(TW), .DEPTH(MAX_ROUND)) u_round_ram (
        .clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
        .raddr(rl_raddr), .rdata(rl_rdata)
    );

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------
    logic              s_fire;
    logic [TW-1:0]     id_slot;
    logic              in_use;
    logic              lvl_end;
    logic [LW-1:0]     lvl_idx;
    logic [CW-1:0]     cnt_lvl;
    logic [3:0]        q4;
    logic [mlfq_pkg::SCHED_W-1:0] fill_cost;
    logic              fill_stop;
    logic              credit_go;
    logic              need_maint;
    logic              disp_go;
    logic              sort_front;
    logic              walk_less;
    logic [QW:0]       credit_sum;
    logic [LW-1:0]     ret_lvl;

    assign s_fire     = s_tvalid && s_tready;
    assign id_slot    = TW'(id_reg);
    assign in_use     = (int'(id_reg) < MAX_THREADS) && slot_used_reg[id_slot];
    assign lvl_end    = (lvl_reg == LCW'(LEVELS));
    assign lvl_idx    = lvl_reg[LW-1:0];
    assign cnt_lvl    = lvl_end ? '0 : cnt_reg[lvl_idx];
    assign q4         = 4'(lvl_reg) + 4'd1;
    assign fill_cost  = sched_reg + mlfq_pkg::SCHED_W'(q4);
    assign fill_stop  = (att_reg == LCW'(LEVELS) - lvl_reg)
                     || (fill_cost > mlfq_pkg::SCHED_W'(budget_reg))
                     || (round_len_reg >= RLW'(MAX_ROUND));
    assign credit_go  = (round_len_reg != '0) && cur_valid_reg;
    assign need_maint = (cursor_reg >= round_len_reg);
    assign disp_go    = (round_len_reg != '0) && (cursor_reg < round_len_reg);
    assign sort_front = (qu_rdata < front_rc_reg);
    assign walk_less  = (qu_rdata < rc_reg);
    assign credit_sum = (QW+1)'(qu_rdata) + (QW+1)'(sl_rdata) + (QW+1)'(1);

    // Old round entry goes back: valued threads above level L3 go to L3, others sink.
    always_comb
    begin
        if ((int'(sl_rdata) > L3) && va_rdata[0])
        begin
            ret_lvl = LW'(L3);
        end
        else if (int'(sl_rdata) + 1 >= LEVELS)
        begin
            ret_lvl = LW'(LEVELS - 1);
        end
        else
        begin
            ret_lvl = LW'(int'(sl_rdata) + 1);
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = mlfq_pkg::ST_DECODE;
                end
            end
            mlfq_pkg::ST_DECODE:
            begin
                if (mode_reg != mlfq_pkg::MODE_YIELD)
                begin
                    state_next = mlfq_pkg::ST_OUT;
                end
                else if (credit_go)
                begin
                    state_next = mlfq_pkg::ST_CREDIT_WR;
                end
                else if (need_maint)
                begin
                    state_next = mlfq_pkg::ST_LIFT;
                end
                else
                begin
                    state_next = mlfq_pkg::ST_DISP_RD;
                end
            end
            mlfq_pkg::ST_CREDIT_WR:
            begin
                state_next = need_maint ? mlfq_pkg::ST_LIFT : mlfq_pkg::ST_DISP_RD;
            end
            mlfq_pkg::ST_LIFT:
            begin
                state_next = mlfq_pkg::ST_SORT_START;
            end
            mlfq_pkg::ST_SORT_START:
            begin
                priority if (lvl_end)
                begin
                    state_next = mlfq_pkg::ST_RET_RD;
                end
                else if (cnt_lvl >= CW'(2))
                begin
                    state_next = mlfq_pkg::ST_SORT_FIRST;
                end
            end
            mlfq_pkg::ST_SORT_FIRST:
            begin
                state_next = mlfq_pkg::ST_SORT_TAKE;
            end
            mlfq_pkg::ST_SORT_TAKE:
            begin
                state_next = mlfq_pkg::ST_SORT_CMP;
            end
            mlfq_pkg::ST_SORT_CMP:
            begin
                if (!sort_front && (sh_reg != st_reg))
                begin
                    state_next = mlfq_pkg::ST_WALK_RD;
                end
                else if (rem_reg == CW'(1))
                begin
                    state_next = mlfq_pkg::ST_SORT_END;
                end
                else
                begin
                    state_next = mlfq_pkg::ST_SORT_TAKE;
                end
            end
            mlfq_pkg::ST_WALK_RD:
            begin
                state_next = mlfq_pkg::ST_WALK_CMP;
            end
            mlfq_pkg::ST_WALK_CMP:
            begin
                priority if (!walk_less)
                begin
                    state_next = mlfq_pkg::ST_WALK_LINK;
                end
                else if (c_reg == st_reg)
                begin
                    state_next = (rem_reg == '0) ? mlfq_pkg::ST_SORT_END
                                                 : mlfq_pkg::ST_SORT_TAKE;
                end
            end
            mlfq_pkg::ST_WALK_LINK:
            begin
                state_next = (rem_reg == '0) ? mlfq_pkg::ST_SORT_END : mlfq_pkg::ST_SORT_TAKE;
            end
            mlfq_pkg::ST_SORT_END:
            begin
                state_next = mlfq_pkg::ST_SORT_START;
            end
            mlfq_pkg::ST_RET_RD:
            begin
                state_next = (k_reg == round_len_reg) ? mlfq_pkg::ST_FILL_TRY
                                                      : mlfq_pkg::ST_RET_INFO;
            end
            mlfq_pkg::ST_RET_INFO:
            begin
                state_next = mlfq_pkg::ST_RET_PUSH;
            end
            mlfq_pkg::ST_RET_PUSH:
            begin
                state_next = mlfq_pkg::ST_RET_RD;
            end
            mlfq_pkg::ST_FILL_TRY:
            begin
                priority if (lvl_end)
                begin
                    state_next = mlfq_pkg::ST_DISP_RD;
                end
                else if (!fill_stop && (cnt_lvl != '0))
                begin
                    state_next = mlfq_pkg::ST_FILL_POP;
                end
            end
            mlfq_pkg::ST_FILL_POP:
            begin
                state_next = mlfq_pkg::ST_FILL_TRY;
            end
            mlfq_pkg::ST_DISP_RD:
            begin
                state_next = disp_go ? mlfq_pkg::ST_DISP_INFO : mlfq_pkg::ST_OUT;
            end
            mlfq_pkg::ST_DISP_INFO:
            begin
                state_next = mlfq_pkg::ST_DISP_RUN;
            end
            mlfq_pkg::ST_DISP_RUN:
            begin
                state_next = mlfq_pkg::ST_OUT;
            end
            mlfq_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = mlfq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mlfq_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next      = mode_reg;
        id_next        = id_reg;
        ns_next        = ns_reg;
        val_next       = val_reg;
        slot_used_next = slot_used_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        round_len_next = round_len_reg;
        cursor_next    = cursor_reg;
        k_next         = k_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        lvl_next       = lvl_reg;
        att_next       = att_reg;
        sched_next     = sched_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        c_next         = c_reg;
        orig_next      = orig_reg;
        sh_next        = sh_reg;
        st_next        = st_reg;
        rem_next       = rem_reg;
        rc_next        = rc_reg;
        front_rc_next  = front_rc_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
        ts_we = 1'b0; ts_waddr = '0; ts_wdata = '0; ts_raddr = '0;
        sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0; sl_raddr = '0;
        va_we = 1'b0; va_waddr = '0; va_wdata = '0; va_raddr = '0;
        qu_we = 1'b0; qu_waddr = '0; qu_wdata = '0; qu_raddr = '0;
        rl_we = 1'b0; rl_waddr = '0; rl_wdata = '0; rl_raddr = '0;

        // Drop the result once the sink takes it.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    mode_next = mlfq_pkg::mode_t'(s_tuser);
                    id_next   = s_tdata[3:0];
                    ns_next   = s_tdata[5:4];
                    val_next  = s_tdata[6];
                end
            end
            mlfq_pkg::ST_DECODE:
            begin
                pend_next = '{valid: 1'b0, thread: 4'd0, slice: 4'd1,
                              status: mlfq_pkg::RES_OK};
                unique case (mode_reg)
                    mlfq_pkg::MODE_CREATE:
                    begin
                        if (int'(id_reg) >= MAX_THREADS)
                        begin
                            pend_next.status = mlfq_pkg::RES_NOT_USED;
                        end
                        else if (slot_used_reg[id_slot])
                        begin
                            pend_next.status = mlfq_pkg::RES_IN_USE;
                        end
                        else
                        begin
                            // New thread: ready, level 0, zero run count, at level 0 tail.
                            slot_used_next[id_slot] = 1'b1;
                            ts_we = 1'b1; ts_waddr = id_slot; ts_wdata = mlfq_pkg::TS_READY;
                            sl_we = 1'b1; sl_waddr = id_slot; sl_wdata = '0;
                            va_we = 1'b1; va_waddr = id_slot; va_wdata = '0;
                            qu_we = 1'b1; qu_waddr = id_slot; qu_wdata = '0;
                            if (cnt_reg[0] == '0)
                            begin
                                head_next[0] = id_slot;
                            end
                            else
                            begin
                                nx_we = 1'b1; nx_waddr = tail_reg[0]; nx_wdata = id_slot;
                            end
                            tail_next[0] = id_slot;
                            cnt_next[0]  = cnt_reg[0] + CW'(1);
                        end
                    end
                    mlfq_pkg::MODE_STATE:
                    begin
                        if (!in_use)
                        begin
                            pend_next.status = mlfq_pkg::RES_NOT_USED;
                        end
                        else if (ns_reg != mlfq_pkg::TS_RUNNING)
                        begin
                            ts_we = 1'b1; ts_waddr = id_slot; ts_wdata = ns_reg;
                        end
                    end
                    mlfq_pkg::MODE_VALUED:
                    begin
                        if (!in_use)
                        begin
                            pend_next.status = mlfq_pkg::RES_NOT_USED;
                        end
                        else
                        begin
                            va_we = 1'b1; va_waddr = id_slot; va_wdata = val_reg;
                        end
                    end
                    mlfq_pkg::MODE_YIELD:
                    begin
                        // Fetch the current thread for its credit.
                        qu_raddr = cur_slot_reg;
                        sl_raddr = cur_slot_reg;
                        ts_raddr = cur_slot_reg;
                    end
                    default:
                    begin
                        pend_next.status = mlfq_pkg::RES_OK;
                    end
                endcase
                lvl_next = '0;
            end
            mlfq_pkg::ST_CREDIT_WR:
            begin
                qu_we    = 1'b1;
                qu_waddr = cur_slot_reg;
                qu_wdata = credit_sum[QW] ? {QW{1'b1}} : credit_sum[QW-1:0];
                if (ts_rdata == mlfq_pkg::TS_RUNNING)
                begin
                    ts_we = 1'b1; ts_waddr = cur_slot_reg; ts_wdata = mlfq_pkg::TS_READY;
                end
            end
            mlfq_pkg::ST_LIFT:
            begin
                // Level 0 takes old level 1 behind its own; every other level moves up.
                cnt_next[0] = cnt_reg[0] + cnt_reg[1];
                if (cnt_reg[0] == '0)
                begin
                    head_next[0] = head_reg[1];
                    tail_next[0] = tail_reg[1];
                end
                else if (cnt_reg[1] != '0)
                begin
                    nx_we = 1'b1; nx_waddr = tail_reg[0]; nx_wdata = head_reg[1];
                    tail_next[0] = tail_reg[1];
                end
                for (int i = 1; i < LEVELS - 1; i++)
                begin
                    head_next[i] = head_reg[i+1];
                    tail_next[i] = tail_reg[i+1];
                    cnt_next[i]  = cnt_reg[i+1];
                end
                cnt_next[LEVELS-1] = '0;
                lvl_next = '0;
            end
            mlfq_pkg::ST_SORT_START:
            begin
                priority if (lvl_end)
                begin
                    k_next = '0;
                end
                else if (cnt_lvl >= CW'(2))
                begin
                    nx_raddr = head_reg[lvl_idx];
                    qu_raddr = head_reg[lvl_idx];
                    sh_next  = head_reg[lvl_idx];
                    st_next  = head_reg[lvl_idx];
                    rem_next = cnt_lvl - CW'(1);
                end
                else
                begin
                    lvl_next = lvl_reg + LCW'(1);
                end
            end
            mlfq_pkg::ST_SORT_FIRST:
            begin
                orig_next     = nx_rdata;
                front_rc_next = qu_rdata;
            end
            mlfq_pkg::ST_SORT_TAKE:
            begin
                x_next   = orig_reg;
                nx_raddr = orig_reg;
                qu_raddr = orig_reg;
            end
            mlfq_pkg::ST_SORT_CMP:
            begin
                // Hold the original successor before the entry is relinked.
                orig_next = nx_rdata;
                rc_next   = qu_rdata;
                rem_next  = rem_reg - CW'(1);
                priority if (sort_front)
                begin
                    nx_we = 1'b1; nx_waddr = x_reg; nx_wdata = sh_reg;
                    sh_next       = x_reg;
                    front_rc_next = qu_rdata;
                end
                else if (sh_reg == st_reg)
                begin
                    nx_we = 1'b1; nx_waddr = st_reg; nx_wdata = x_reg;
                    st_next = x_reg;
                end
                else
                begin
                    p_next   = sh_reg;
                    nx_raddr = sh_reg;
                end
            end
            mlfq_pkg::ST_WALK_RD:
            begin
                c_next   = nx_rdata;
                nx_raddr = nx_rdata;
                qu_raddr = nx_rdata;
            end
            mlfq_pkg::ST_WALK_CMP:
            begin
                priority if (!walk_less)
                begin
                    nx_we = 1'b1; nx_waddr = p_reg; nx_wdata = x_reg;
                end
                else if (c_reg == st_reg)
                begin
                    nx_we = 1'b1; nx_waddr = c_reg; nx_wdata = x_reg;
                    st_next = x_reg;
                end
                else
                begin
                    // Advance one node along the sorted part.
                    p_next   = c_reg;
                    c_next   = nx_rdata;
                    nx_raddr = nx_rdata;
                    qu_raddr = nx_rdata;
                end
            end
            mlfq_pkg::ST_WALK_LINK:
            begin
                nx_we = 1'b1; nx_waddr = x_reg; nx_wdata = c_reg;
            end
            mlfq_pkg::ST_SORT_END:
            begin
                head_next[lvl_idx] = sh_reg;
                tail_next[lvl_idx] = st_reg;
                lvl_next           = lvl_reg + LCW'(1);
            end
            mlfq_pkg::ST_RET_RD:
            begin
                if (k_reg == round_len_reg)
                begin
                    round_len_next = '0;
                    cursor_next    = '0;
                    sched_next     = '0;
                    lvl_next       = '0;
                    att_next       = '0;
                end
                else
                begin
                    rl_raddr = k_reg[RIW-1:0];
                end
            end
            mlfq_pkg::ST_RET_INFO:
            begin
                x_next   = rl_rdata;
                ts_raddr = rl_rdata;
                sl_raddr = rl_rdata;
                va_raddr = rl_rdata;
            end
            mlfq_pkg::ST_RET_PUSH:
            begin
                if (ts_rdata == mlfq_pkg::TS_TERMINATED)
                begin
                    slot_used_next[x_reg] = 1'b0;
                end
                else
                begin
                    if (cnt_reg[ret_lvl] == '0)
                    begin
                        head_next[ret_lvl] = x_reg;
                    end
                    else
                    begin
                        nx_we = 1'b1; nx_waddr = tail_reg[ret_lvl]; nx_wdata = x_reg;
                    end
                    tail_next[ret_lvl] = x_reg;
                    cnt_next[ret_lvl]  = cnt_reg[ret_lvl] + CW'(1);
                end
                k_next = k_reg + RLW'(1);
            end
            mlfq_pkg::ST_FILL_TRY:
            begin
                priority if (lvl_end)
                begin
                    att_next = '0;
                end
                else if (fill_stop)
                begin
                    lvl_next = lvl_reg + LCW'(1);
                    att_next = '0;
                end
                else if (cnt_lvl == '0)
                begin
                    att_next = att_reg + LCW'(1);
                end
                else
                begin
                    x_next   = head_reg[lvl_idx];
                    ts_raddr = head_reg[lvl_idx];
                    nx_raddr = head_reg[lvl_idx];
                end
            end
            mlfq_pkg::ST_FILL_POP:
            begin
                att_next = att_reg + LCW'(1);
                if (ts_rdata == mlfq_pkg::TS_READY)
                begin
                    head_next[lvl_idx] = nx_rdata;
                    cnt_next[lvl_idx]  = cnt_lvl - CW'(1);
                    sched_next         = fill_cost;
                    sl_we = 1'b1; sl_waddr = x_reg; sl_wdata = SW'(lvl_reg);
                    rl_we = 1'b1; rl_waddr = round_len_reg[RIW-1:0]; rl_wdata = x_reg;
                    round_len_next     = round_len_reg + RLW'(1);
                end
                else if (cnt_lvl != CW'(1))
                begin
                    // Not ready: rotate the head to the tail.
                    nx_we = 1'b1; nx_waddr = tail_reg[lvl_idx]; nx_wdata = x_reg;
                    head_next[lvl_idx] = nx_rdata;
                    tail_next[lvl_idx] = x_reg;
                end
            end
            mlfq_pkg::ST_DISP_RD:
            begin
                if (disp_go)
                begin
                    rl_raddr = cursor_reg[RIW-1:0];
                end
                else
                begin
                    cur_valid_next = 1'b0;
                end
            end
            mlfq_pkg::ST_DISP_INFO:
            begin
                x_next   = rl_rdata;
                sl_raddr = rl_rdata;
            end
            mlfq_pkg::ST_DISP_RUN:
            begin
                ts_we = 1'b1; ts_waddr = x_reg; ts_wdata = mlfq_pkg::TS_RUNNING;
                cursor_next    = cursor_reg + RLW'(1);
                cur_slot_next  = x_reg;
                cur_valid_next = 1'b1;
                pend_next.valid  = 1'b1;
                pend_next.thread = 4'(x_reg);
                pend_next.slice  = 4'(sl_rdata) + 4'd1;
            end
            mlfq_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlfq_pkg::ST_IDLE;
            budget_reg    <= 7'd15;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                slot_used_reg[i] <= 1'b0;
            end
            for (int i = 0; i < LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            round_len_reg <= '0;
            cursor_reg    <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
            slot_used_reg <= slot_used_next;
            cnt_reg       <= cnt_next;
            round_len_reg <= round_len_next;
            cursor_reg    <= cursor_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        ns_reg       <= ns_next;
        val_reg      <= val_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        k_reg        <= k_next;
        lvl_reg      <= lvl_next;
        att_reg      <= att_next;
        sched_reg    <= sched_next;
        x_reg        <= x_next;
        p_reg        <= p_next;
        c_reg        <= c_next;
        orig_reg     <= orig_next;
        sh_reg       <= sh_next;
        st_reg       <= st_next;
        rem_reg      <= rem_next;
        rc_reg       <= rc_next;
        front_rc_reg <= front_rc_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == mlfq_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.slice, out_reg.thread};
    assign m_tuser  = out_reg.valid;

endmodule
